/* design/oled_framebuffer_refresh_engine_top_assert.svh */
// Assertion macros for the frame buffer refresh engine modules.
`ifndef OLED_FRAMEBUFFER_REFRESH_ENGINE_TOP_ASSERT_SVH
`define OLED_FRAMEBUFFER_REFRESH_ENGINE_TOP_ASSERT_SVH

// cond holds at every clock edge out of reset
`define OFB_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cons holds in the same cycle as ante
`define OFB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// cons holds in the cycle after ante
`define OFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/oled_fb_pkg.sv */
// Shared types and constants of the frame buffer refresh engine.
`default_nettype none

package oled_fb_pkg;

  localparam int DEF_COLUMNS = 128;
  localparam int DEF_PAGES   = 8;
  localparam int DEF_STORE_AW = 10;

  localparam int POS_W        = 8;
  localparam int HEADER_BYTES = 3;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_START = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef struct packed {
    logic       load;
    logic       is_data;
    logic [7:0] byte_value;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

/* design/oled_fb_store.sv */
// Frame store memory: one write port, one registered read port.
`default_nettype none

module oled_fb_store import oled_fb_pkg::*; #(
  parameter int ADDR_W = DEF_STORE_AW
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [7:0]        wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [7:0]        rd_data
);

  logic [7:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* design/oled_fb_ctrl.sv */
// Sequencer: draw read-modify-write, refresh byte stepping and store clearing.
`default_nettype none

`include "oled_framebuffer_refresh_engine_top_assert.svh"

module oled_fb_ctrl import oled_fb_pkg::*; #(
  parameter  int COLUMNS = DEF_COLUMNS,
  parameter  int PAGES   = DEF_PAGES,
  localparam int COL_W   = $clog2(COLUMNS),
  localparam int PAGE_W  = (PAGES > 1) ? $clog2(PAGES) : 1,
  localparam int ADDR_W  = PAGE_W + COL_W
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        operation,
  input  wire logic [7:0]        x_column,
  input  wire logic [7:0]        y_row,
  input  wire logic              pixel_on,
  input  wire logic              out_free,
  output result_t                res,
  output logic                   mem_wr_en,
  output logic      [ADDR_W-1:0] mem_wr_addr,
  output logic      [7:0]        mem_wr_data,
  output logic                   mem_rd_en,
  output logic      [ADDR_W-1:0] mem_rd_addr,
  input  wire logic [7:0]        mem_rd_data
);

  localparam logic [8:0]        COL_LIMIT = 9'(COLUMNS);
  localparam logic [8:0]        ROW_LIMIT = 9'(8 * PAGES);
  localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGES - 1);
  localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(HEADER_BYTES + COLUMNS - 1);
  localparam logic [POS_W-1:0]  HDR_END   = POS_W'(HEADER_BYTES);
  localparam logic [ADDR_W-1:0] SWEEP_END = '1;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_DRAW_WB = 4'b0010,
    ST_TICK_RD = 4'b0100,
    ST_CLEAR   = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic              active, active_next;
  logic [PAGE_W-1:0] page, page_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [ADDR_W-1:0] sweep, sweep_next;

  logic [ADDR_W-1:0] pend_addr;
  logic [7:0]        pend_mask;
  logic              pend_on;
  logic              pend_last;

  logic              accept;
  op_t               op;
  logic              draw_hit;
  logic [PAGE_W-1:0] draw_page;
  logic [7:0]        draw_mask;
  logic [ADDR_W-1:0] draw_addr;
  logic [COL_W-1:0]  data_col;
  logic              tick_last;
  logic [7:0]        header_byte;

  assign in_stall = !((state == ST_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;
  assign op       = op_t'(operation);

  // rows are flipped: top row lands in the last page, high bit
  assign draw_hit  = ({1'b0, x_column} < COL_LIMIT) && ({1'b0, y_row} < ROW_LIMIT);
  assign draw_page = PAGE_LAST - y_row[3 +: PAGE_W];
  assign draw_mask = 8'h80 >> y_row[2:0];
  assign draw_addr = {draw_page, x_column[COL_W-1:0]};
  assign data_col  = COL_W'(pos - HDR_END);
  assign tick_last = (pos == LAST_POS) && (page == PAGE_LAST);

  always_comb begin
    case (pos[1:0])
      2'd0:    header_byte = CMD_PAGE_BASE + 8'(page);
      2'd1:    header_byte = CMD_COL_LOW;
      default: header_byte = CMD_COL_HIGH;
    endcase
  end

  always_comb begin
    state_next  = state;
    active_next = active;
    page_next   = page;
    pos_next    = pos;
    sweep_next  = sweep;
    mem_wr_en   = 1'b0;
    mem_wr_addr = sweep;
    mem_wr_data = '0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = draw_addr;
    res         = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_DRAW: begin
              if (draw_hit) begin
                mem_rd_en  = 1'b1;
                state_next = ST_DRAW_WB;
              end
            end
            OP_CLEAR: begin
              sweep_next  = '0;
              state_next  = ST_CLEAR;
              active_next = 1'b1;
              page_next   = '0;
              pos_next    = '0;
            end
            OP_START: begin
              active_next = 1'b1;
              page_next   = '0;
              pos_next    = '0;
            end
            OP_TICK: begin
              if (active) begin
                if (pos == LAST_POS) begin
                  pos_next = '0;
                  if (page == PAGE_LAST) begin
                    active_next = 1'b0;
                    page_next   = '0;
                  end else begin
                    page_next = page + 1'b1;
                  end
                end else begin
                  pos_next = pos + 1'b1;
                end
                if (pos < HDR_END) begin
                  res.load       = 1'b1;
                  res.is_data    = 1'b0;
                  res.byte_value = header_byte;
                  res.last       = 1'b0;
                end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = {page, data_col};
                  state_next  = ST_TICK_RD;
                end
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_DRAW_WB: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = pend_addr;
        mem_wr_data = pend_on ? (mem_rd_data | pend_mask) : (mem_rd_data & ~pend_mask);
        state_next  = ST_IDLE;
      end
      ST_TICK_RD: begin
        res.load       = 1'b1;
        res.is_data    = 1'b1;
        res.byte_value = mem_rd_data;
        res.last       = pend_last;
        state_next     = ST_IDLE;
      end
      ST_CLEAR: begin
        mem_wr_en  = 1'b1;
        sweep_next = sweep + 1'b1;
        if (sweep == SWEEP_END) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      active <= 1'b0;
      page   <= '0;
      pos    <= '0;
      sweep  <= '0;
    end else begin
      state  <= state_next;
      active <= active_next;
      page   <= page_next;
      pos    <= pos_next;
      sweep  <= sweep_next;
    end
  end

  // hold the draw target and the last flag for the cycle after the read
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_addr <= draw_addr;
      pend_mask <= draw_mask;
      pend_on   <= pixel_on;
      pend_last <= tick_last;
    end
  end

  `OFB_ASSERT_ALWAYS(a_pos_range, pos <= LAST_POS, "byte position past end of line")
  `OFB_ASSERT_IMPL(a_idle_home, !active, (pos == '0) && (page == '0), "idle with counters away from home")
  `OFB_ASSERT_IMPL(a_write_no_accept, mem_wr_en, !accept, "item accepted during a store write")
  `OFB_ASSERT_IMPL(a_read_result, state == ST_TICK_RD, res.load && out_free, "data byte has no free output slot")

endmodule

`default_nettype wire

/* design/oled_framebuffer_refresh_engine_top.sv */
// Top level of the page-mode frame buffer refresh engine.
//
//   channel  signals                                   direction
//   in       in_valid/in_stall, operation, x_column,   into block
//            y_row, pixel_on
//   out      out_valid/out_stall, is_data, byte_value, out of block
//            last_of_frame
//
// An on-screen draw reads the store, then writes back in ST_DRAW_WB; an
// off-screen draw, a start and a tick while idle end in ST_IDLE.
// A tick gives a command byte from ST_IDLE or a data byte via ST_TICK_RD.
// Clear writes zero to all 2**(page bits + column bits) store bytes (1024
// at 128 x 8); after reset the same clearing pass runs while in_stall
// stays high.
// While a result waits under out_stall, in_stall stays high.
`default_nettype none

module oled_framebuffer_refresh_engine_top import oled_fb_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int PAGES   = DEF_PAGES
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] operation,
  input  wire logic [7:0] x_column,
  input  wire logic [7:0] y_row,
  input  wire logic       pixel_on,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            is_data,
  output logic      [7:0] byte_value,
  output logic            last_of_frame
);

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int ADDR_W = PAGE_W + COL_W;

  result_t           res;
  logic              out_free;
  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [7:0]        mem_wr_data;
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic [7:0]        mem_rd_data;

  assign out_free = !out_valid || !out_stall;

  oled_fb_ctrl #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .x_column    (x_column),
    .y_row       (y_row),
    .pixel_on    (pixel_on),
    .out_free    (out_free),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  oled_fb_store #(
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      is_data       <= res.is_data;
      byte_value    <= res.byte_value;
      last_of_frame <= res.last;
    end
  end

endmodule

`default_nettype wire
